FILE: src/current_peak_average_monitor_defines.svh
// Assertion macros used by the monitor's checker file.
`ifndef CURRENT_PEAK_AVERAGE_MONITOR_DEFINES_SVH
`define CURRENT_PEAK_AVERAGE_MONITOR_DEFINES_SVH

// Clocked check, switched off while reset is asserted.
`define CPAM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define CPAM_ASSERT_RST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/cpam_pkg.sv
// Shared types, constants and functions of the current peak/average monitor.
`timescale 1ns / 1ps

package cpam_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int COUNT_W    = 16;
	localparam int CURRENT_W  = 13;
	localparam int SCALE_W    = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
	// Divide by 512 after scaling.
	localparam int SCALE_SHIFT = 9;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_ZERO_OFFSET    = 3'd0;
	localparam cfg_idx_t REG_RECTIFY_ON     = 3'd1;
	localparam cfg_idx_t REG_AVERAGING_ON   = 3'd2;
	localparam cfg_idx_t REG_MODEL_RANGE    = 3'd3;
	localparam cfg_idx_t REG_PERIOD_SAMPLES = 3'd4;

	typedef enum logic [1:0] {
		RANGE_500  = 2'd0,
		RANGE_2000 = 2'd1,
		RANGE_3000 = 2'd2
	} range_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] zero_offset;
		logic                rectify_on;
		logic [COUNT_W-1:0]  period_samples;
	} cfg_front_t;

	typedef struct packed {
		logic       averaging_on;
		logic [1:0] model_range;
	} cfg_back_t;

	// Full scale in milliamp units; the unused code takes the largest range.
	function automatic logic [SCALE_W-1:0] full_scale(input logic [1:0] code);
		logic [SCALE_W-1:0] fs;
		unique case (code)
			RANGE_500:  fs = 12'd500;
			RANGE_2000: fs = 12'd2000;
			default:    fs = 12'd3000;
		endcase
		return fs;
	endfunction

endpackage

FILE: src/cpam_front.sv
// Sample front end: offset correction, rectification, period peak tracking.
`timescale 1ns / 1ps

module cpam_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cpam_pkg::cfg_front_t          cfg,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cpam_pkg::SAMPLE_W-1:0] sample,
	output logic                          push_valid,
	output logic [cpam_pkg::SAMPLE_W-1:0] push_peak,
	input  logic                          push_full
);
	import cpam_pkg::*;

	logic [SAMPLE_W-1:0] running_peak_q;
	logic [COUNT_W-1:0]  sample_count_q;

	logic                accept;
	logic signed [SAMPLE_W:0] diff;
	logic signed [SAMPLE_W:0] corrected;
	logic [SAMPLE_W-1:0] peak_next;
	logic [COUNT_W-1:0]  count_next;
	logic [COUNT_W-1:0]  period;
	logic                period_end;

	assign in_stall = push_full;
	assign accept   = in_valid && !push_full;

	always_comb begin
		diff      = $signed({1'b0, sample}) - $signed({1'b0, cfg.zero_offset});
		corrected = (cfg.rectify_on && diff[SAMPLE_W]) ? -diff : diff;
		// Negative values never beat a peak that starts at zero.
		if (!corrected[SAMPLE_W] && (corrected[SAMPLE_W-1:0] > running_peak_q)) begin
			peak_next = corrected[SAMPLE_W-1:0];
		end else begin
			peak_next = running_peak_q;
		end
		period     = (cfg.period_samples == '0) ? COUNT_W'(1) : cfg.period_samples;
		count_next = sample_count_q + COUNT_W'(1);
		period_end = (count_next == '0) || (count_next >= period);
	end

	assign push_valid = accept && period_end;
	assign push_peak  = peak_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_peak_q <= '0;
			sample_count_q <= '0;
		end else if (accept) begin
			running_peak_q <= period_end ? '0 : peak_next;
			sample_count_q <= period_end ? '0 : count_next;
		end
	end

endmodule

FILE: src/cpam_fifo.sv
// Short peak queue between the sample front end and the window back end.
`timescale 1ns / 1ps

module cpam_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push_valid,
	input  logic [cpam_pkg::SAMPLE_W-1:0] push_peak,
	output logic                          full,
	output logic                          pop_valid,
	output logic [cpam_pkg::SAMPLE_W-1:0] pop_peak,
	input  logic                          pop_ready
);
	import cpam_pkg::*;

	logic [SAMPLE_W-1:0]   slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full      = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_peak  = slot_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_peak;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + FIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - FIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/cpam_back.sv
// Window back end: moving-window sum, average and milliamp scaling pipeline.
`timescale 1ns / 1ps

module cpam_back #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cpam_pkg::cfg_back_t            cfg,
	input  logic                           pop_valid,
	input  logic [cpam_pkg::SAMPLE_W-1:0]  pop_peak,
	output logic                           pop_ready,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [cpam_pkg::SAMPLE_W-1:0]  period_peak,
	output logic [cpam_pkg::SAMPLE_W-1:0]  average_peak,
	output logic [cpam_pkg::CURRENT_W-1:0] current_ma
);
	import cpam_pkg::*;

	localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SUM_W = $clog2(WINDOW_DEPTH * 1023 + 1);
	localparam int LG    = $clog2(WINDOW_DEPTH);
	localparam int SH    = SUM_W + LG;
	localparam int RW    = SUM_W + 2;
	localparam int PW    = SUM_W + RW;
	// Rounded-up reciprocal: exact floor division for every SUM_W-bit sum.
	localparam longint unsigned RECIP =
		((longint'(1) << SH) + longint'(WINDOW_DEPTH) - 1) / longint'(WINDOW_DEPTH);
	localparam int MW    = SAMPLE_W + SCALE_W;

	logic [SAMPLE_W-1:0] win_mem [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] win_vld_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [PTR_W-1:0]    ptr_inc;
	logic [PTR_W-1:0]    rd_addr;
	logic [SUM_W-1:0]    window_sum_q;
	logic [SUM_W-1:0]    sum_new;
	logic [SAMPLE_W-1:0] old_entry;
	logic                pop_take;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic                adv1, adv2, adv3, adv4;
	logic [SAMPLE_W-1:0] peak_s1, peak_s2, peak_s3, peak_s4;
	logic [SAMPLE_W-1:0] old_mem_s1;
	logic                old_vld_s1;
	logic                byp_s1;
	logic [SAMPLE_W-1:0] byp_data_s1;
	logic [SUM_W-1:0]    sum_s2;
	logic [SAMPLE_W-1:0] avg_s3, avg_s4;
	logic [CURRENT_W-1:0] ma_s4;

	logic [PW-1:0]       avg_prod;
	logic [SAMPLE_W-1:0] sel;
	logic [MW-1:0]       ma_prod;

	// Stage handshake: a stage advances when the next one is empty or moving.
	assign adv4      = v_s4 && !out_stall;
	assign adv3      = v_s3 && (!v_s4 || adv4);
	assign adv2      = v_s2 && (!v_s3 || adv3);
	assign adv1      = v_s1 && (!v_s2 || adv2);
	assign pop_ready = !v_s1 || adv1;
	assign pop_take  = pop_valid && pop_ready;

	assign ptr_inc = (ptr_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + PTR_W'(1);
	// The incoming peak reads the slot after any slot written this cycle, else the current one.
	assign rd_addr = adv1 ? ptr_inc : ptr_q;

	always_comb begin
		if (byp_s1) begin
			old_entry = byp_data_s1;
		end else if (old_vld_s1) begin
			old_entry = old_mem_s1;
		end else begin
			old_entry = '0;
		end
		sum_new  = window_sum_q - SUM_W'(old_entry) + SUM_W'(peak_s1);
		avg_prod = PW'(sum_s2) * PW'(RECIP);
		sel      = cfg.averaging_on ? avg_s3 : peak_s3;
		ma_prod  = MW'(sel) * MW'(full_scale(cfg.model_range));
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			win_mem[ptr_q] <= peak_s1;
		end
		if (pop_take) begin
			old_mem_s1  <= win_mem[rd_addr];
			old_vld_s1  <= win_vld_q[rd_addr];
			byp_s1      <= adv1 && (rd_addr == ptr_q);
			byp_data_s1 <= peak_s1;
			peak_s1     <= pop_peak;
		end
		if (adv1) begin
			peak_s2 <= peak_s1;
			sum_s2  <= sum_new;
		end
		if (adv2) begin
			peak_s3 <= peak_s2;
			avg_s3  <= avg_prod[SH+SAMPLE_W-1:SH];
		end
		if (adv3) begin
			peak_s4 <= peak_s3;
			avg_s4  <= avg_s3;
			ma_s4   <= ma_prod[SCALE_SHIFT+CURRENT_W-1:SCALE_SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			ptr_q        <= '0;
			window_sum_q <= '0;
			win_vld_q    <= '0;
		end else begin
			v_s1 <= pop_take || (v_s1 && !adv1);
			v_s2 <= adv1 || (v_s2 && !adv2);
			v_s3 <= adv2 || (v_s3 && !adv3);
			v_s4 <= adv3 || (v_s4 && !adv4);
			if (adv1) begin
				ptr_q            <= ptr_inc;
				window_sum_q     <= sum_new;
				win_vld_q[ptr_q] <= 1'b1;
			end
		end
	end

	assign out_valid    = v_s4;
	assign period_peak  = peak_s4;
	assign average_peak = avg_s4;
	assign current_ma   = ma_s4;

endmodule

FILE: src/current_peak_average_monitor.sv
// Top level of the current peak and moving-average monitor.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | in_valid / in_stall  | sample
//   output   | out_valid / out_stall| period_peak, average_peak, current_ma
//   config   | cfg_we               | cfg_index, cfg_data
//
// One sample is taken every cycle while in_stall is low; the front end handles it in the cycle it is taken.
// A period result reaches the output through a four-entry queue and a four-stage
// window/average/scale pipeline; results stream at one per cycle while out_stall is low.
// The window store has per-entry valid bits, so reset
// is immediate with no clearing pass. in_stall rises only when the queue is full, which
// happens only when out_stall has held results back.
`timescale 1ns / 1ps

module current_peak_average_monitor #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cpam_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpam_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [cpam_pkg::SAMPLE_W-1:0]   sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [cpam_pkg::SAMPLE_W-1:0]   period_peak,
	output logic [cpam_pkg::SAMPLE_W-1:0]   average_peak,
	output logic [cpam_pkg::CURRENT_W-1:0]  current_ma
);
	import cpam_pkg::*;

	cfg_front_t          cfg_front_q;
	cfg_back_t           cfg_back_q;
	logic                push_valid;
	logic [SAMPLE_W-1:0] push_peak;
	logic                fifo_full;
	logic                pop_valid;
	logic [SAMPLE_W-1:0] pop_peak;
	logic                pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_front_q.zero_offset    <= '0;
			cfg_front_q.rectify_on     <= 1'b1;
			cfg_front_q.period_samples <= 16'd320;
			cfg_back_q.averaging_on    <= 1'b0;
			cfg_back_q.model_range     <= RANGE_500;
		end else if (cfg_we) begin
			// Drop writes to indexes outside the register list.
			unique case (cfg_index)
				REG_ZERO_OFFSET:    cfg_front_q.zero_offset    <= cfg_data[SAMPLE_W-1:0];
				REG_RECTIFY_ON:     cfg_front_q.rectify_on     <= cfg_data[0];
				REG_AVERAGING_ON:   cfg_back_q.averaging_on    <= cfg_data[0];
				REG_MODEL_RANGE:    cfg_back_q.model_range     <= cfg_data[1:0];
				REG_PERIOD_SAMPLES: cfg_front_q.period_samples <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	cpam_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_front_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.push_valid (push_valid),
		.push_peak  (push_peak),
		.push_full  (fifo_full)
	);

	cpam_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_peak  (push_peak),
		.full       (fifo_full),
		.pop_valid  (pop_valid),
		.pop_peak   (pop_peak),
		.pop_ready  (pop_ready)
	);

	cpam_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_back_q),
		.pop_valid    (pop_valid),
		.pop_peak     (pop_peak),
		.pop_ready    (pop_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.period_peak  (period_peak),
		.average_peak (average_peak),
		.current_ma   (current_ma)
	);

endmodule

FILE: src/cpam_checker.sv
// Port-level checks of the monitor and their bind to the top level.
`timescale 1ns / 1ps
`include "current_peak_average_monitor_defines.svh"

module cpam_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_we,
	input logic [cpam_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [cpam_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic [cpam_pkg::SAMPLE_W-1:0]   sample,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [cpam_pkg::SAMPLE_W-1:0]   period_peak,
	input logic [cpam_pkg::SAMPLE_W-1:0]   average_peak,
	input logic [cpam_pkg::CURRENT_W-1:0]  current_ma
);
	import cpam_pkg::*;

	logic unused_ok;
	assign unused_ok = cfg_we ^ (|cfg_index) ^ (|cfg_data) ^ in_valid ^ (|sample)
		^ (|period_peak) ^ (|average_peak);

	property p_out_hold;
		out_valid && out_stall |=> out_valid && $stable(period_peak)
			&& $stable(average_peak) && $stable(current_ma);
	endproperty

	// A stalled result transaction holds its payload.
	`CPAM_ASSERT(a_out_hold, clk, arst_n, p_out_hold, "stalled result changed")
	// Scaled current never exceeds 1023 * 3000 / 512.
	`CPAM_ASSERT(a_ma_bound, clk, arst_n, out_valid |-> current_ma <= 13'd5994, "current out of range")
	// A reset edge empties the result pipeline.
	`CPAM_ASSERT_RST(a_rst_empty, clk, !arst_n |=> !out_valid, "result valid after reset")
	// The queue is empty coming out of reset, so samples are taken at once.
	`CPAM_ASSERT_RST(a_rst_ready, clk, $rose(arst_n) |-> !in_stall, "input stalled after reset")

endmodule

bind current_peak_average_monitor cpam_checker u_cpam_checker (.*);

FILE: tb/peak_average_checker.sv
// Checker for the current peak/average monitor: predicts period reports and compares them.
`timescale 1ns / 1ps

module peak_average_checker
	import cpam_pkg::*;
#(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [SAMPLE_W-1:0]   sample,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [SAMPLE_W-1:0]   period_peak,
	input  logic [SAMPLE_W-1:0]   average_peak,
	input  logic [CURRENT_W-1:0]  current_ma,
	output int                    pending,
	output int                    fail_count
);

	localparam int FS_500_MA    = 500;
	localparam int FS_2000_MA   = 2000;
	localparam int FS_3000_MA   = 3000;
	localparam int SCALE_DIV    = 512;
	localparam int MAX_REPORTED = 10;

	typedef struct packed {
		logic [SAMPLE_W-1:0]  peak;
		logic [SAMPLE_W-1:0]  average;
		logic [CURRENT_W-1:0] current;
	} period_report_t;

	// configuration copy
	logic [SAMPLE_W-1:0] zero_off;
	logic                rect_on;
	logic                avg_on;
	logic [1:0]          range_code;
	logic [COUNT_W-1:0]  period_len;

	// running state
	logic [SAMPLE_W-1:0] running_peak;
	logic [COUNT_W-1:0]  sample_count;
	int                  peak_hist [WINDOW_DEPTH];
	int                  hist_ptr;
	int                  window_sum;

	period_report_t reports_due [$];
	period_report_t due;
	period_report_t seen;

	initial begin
		pending = 0;
		fail_count = 0;
	end

	function automatic int full_scale_ma(input logic [1:0] code);
		case (code)
			RANGE_500:  return FS_500_MA;
			RANGE_2000: return FS_2000_MA;
			default:    return FS_3000_MA;
		endcase
	endfunction

	task automatic clear_model();
		zero_off = '0;
		rect_on = 1'b1;
		avg_on = 1'b0;
		range_code = RANGE_500;
		period_len = 16'd320;
		running_peak = '0;
		sample_count = '0;
		foreach (peak_hist[i]) peak_hist[i] = 0;
		hist_ptr = 0;
		window_sum = 0;
		reports_due.delete();
	endtask

	// Fold one accepted sample into the period; queue a report when the period closes.
	task automatic take_sample(input logic [SAMPLE_W-1:0] raw);
		int corrected;
		int span;
		int peak;
		int average;
		int chosen;
		period_report_t rep;
		corrected = int'(raw) - int'(zero_off);
		if (rect_on && corrected < 0) corrected = -corrected;
		if (corrected > int'(running_peak)) running_peak = corrected[SAMPLE_W-1:0];
		sample_count = sample_count + 1'b1;
		// zero period behaves as one
		span = (period_len == 0) ? 1 : int'(period_len);
		if (sample_count != 0 && int'(sample_count) < span) return;
		peak = int'(running_peak);
		window_sum = window_sum - peak_hist[hist_ptr] + peak;
		peak_hist[hist_ptr] = peak;
		hist_ptr = (hist_ptr + 1) % WINDOW_DEPTH;
		average = window_sum / WINDOW_DEPTH;
		chosen = avg_on ? average : peak;
		rep.peak = peak[SAMPLE_W-1:0];
		rep.average = average[SAMPLE_W-1:0];
		rep.current = CURRENT_W'((chosen * full_scale_ma(range_code)) / SCALE_DIV);
		reports_due.push_back(rep);
		running_peak = '0;
		sample_count = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ZERO_OFFSET:    zero_off = cfg_data[SAMPLE_W-1:0];
					REG_RECTIFY_ON:     rect_on = cfg_data[0];
					REG_AVERAGING_ON:   avg_on = cfg_data[0];
					REG_MODEL_RANGE:    range_code = cfg_data[1:0];
					REG_PERIOD_SAMPLES: period_len = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				seen = '{period_peak, average_peak, current_ma};
				if (reports_due.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTED)
						$display("%0t: report with none due: peak %0d average %0d current %0d",
							$realtime, period_peak, average_peak, current_ma);
				end else begin
					due = reports_due.pop_front();
					if (due !== seen) begin
						fail_count++;
						if (fail_count <= MAX_REPORTED)
							$display("%0t: report mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
								$realtime, due.peak, due.average, due.current,
								seen.peak, seen.average, seen.current);
					end
				end
			end
			if (in_valid && !in_stall) take_sample(sample);
		end
		pending = reports_due.size();
	end

endmodule

FILE: tb/current_peak_average_monitor_test.sv
// Testbench top for the current peak/average monitor: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module current_peak_average_monitor_test;
	import cpam_pkg::*;

	localparam int WINDOW_DEPTH    = 16;
	localparam int HALF_PERIOD     = 2;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int SETTLE_CYCLES   = 10;
	localparam int LONG_HOLD       = 300;
	localparam int ROUNDS          = 4;
	localparam int ROUND_ITEMS     = 50;
	localparam int PRESSURE_ITEMS  = 80;
	localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
	localparam int REG_SPARE_FIRST = REG_PERIOD_SAMPLES + 1;
	localparam int REG_SPARE_LAST  = (1 << CFG_IDX_W) - 1;
	localparam logic [1:0] RANGE_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [SAMPLE_W-1:0]   sample = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [SAMPLE_W-1:0]   period_peak;
	logic [SAMPLE_W-1:0]   average_peak;
	logic [CURRENT_W-1:0]  current_ma;
	int                    pending;
	int                    fail_count;

	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	int                  sender_idle_pct [3] = '{38, 65, 0};
	int                  receiver_idle_pct [3] = '{65, 38, 0};
	logic                long_hold_go = 1'b0;
	logic                long_hold_done = 1'b0;
	int                  hold_count = 0;
	int                  cycle_count = 0;
	logic [SAMPLE_W-1:0] cur_offset = '0;

	current_peak_average_monitor #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.period_peak(period_peak),
		.average_peak(average_peak),
		.current_ma(current_ma)
	);

	peak_average_checker #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.period_peak(period_peak),
		.average_peak(average_peak),
		.current_ma(current_ma),
		.pending(pending),
		.fail_count(fail_count)
	);

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off to back the block up.
	always @(negedge clk) begin
		if (long_hold_go && !long_hold_done) begin
			out_stall <= 1'b1;
			hold_count++;
			if (hold_count >= LONG_HOLD) long_hold_done = 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Hold the payload until the transaction is taken; returns at a falling edge.
	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			sample <= SAMPLE_W'($urandom_range(SAMPLE_MAX));
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Unused data bits carry noise; the block must ignore them.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value,
			input int width);
		logic [CFG_DATA_W-1:0] keep;
		keep = CFG_DATA_W'((32'd1 << width) - 1);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= (CFG_DATA_W'($urandom) & ~keep) | (value & keep);
		@(negedge clk);
	endtask

	task automatic apply_config(input logic [SAMPLE_W-1:0] offset, input logic rect,
			input logic avg, input logic [1:0] range_sel, input logic [COUNT_W-1:0] period);
		cur_offset = offset;
		write_reg(REG_ZERO_OFFSET, CFG_DATA_W'(offset), SAMPLE_W);
		write_reg(REG_RECTIFY_ON, CFG_DATA_W'(rect), 1);
		write_reg(REG_AVERAGING_ON, CFG_DATA_W'(avg), 1);
		write_reg(REG_MODEL_RANGE, CFG_DATA_W'(range_sel), 2);
		write_reg(REG_PERIOD_SAMPLES, CFG_DATA_W'(period), COUNT_W);
		write_reg(cfg_idx_t'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
			CFG_DATA_W'($urandom), CFG_DATA_W);
		cfg_we <= 1'b0;
	endtask

	// Drop valid, wait for every due report, then let the pipeline settle.
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int near;
		case ($urandom_range(7))
			0: return '0;
			1: return SAMPLE_W'(SAMPLE_MAX);
			2, 3: begin
				near = int'(cur_offset) + int'($urandom_range(40)) - 20;
				if (near < 0) near = 0;
				if (near > SAMPLE_MAX) near = SAMPLE_MAX;
				return near[SAMPLE_W-1:0];
			end
			default: return SAMPLE_W'($urandom_range(SAMPLE_MAX));
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_offset();
		case ($urandom_range(3))
			0: return '0;
			1: return SAMPLE_W'(SAMPLE_MAX);
			default: return SAMPLE_W'($urandom_range(SAMPLE_MAX));
		endcase
	endfunction

	initial begin
		logic [COUNT_W-1:0] period_pick;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// every sample closes a period; peaks at both ends of the range
		apply_config('0, 1'b1, 1'b0, RANGE_500, 16'd1);
		send_sample('0);
		send_sample(SAMPLE_W'(SAMPLE_MAX));
		send_sample(10'd512);
		// rectify off: samples below the offset never lift the peak
		drain_and_settle();
		apply_config(10'd512, 1'b0, 1'b0, RANGE_2000, 16'd1);
		send_sample('0);
		send_sample(SAMPLE_W'(SAMPLE_MAX));
		send_sample(10'd511);
		// zero period acts as one, averaging on, largest offset
		drain_and_settle();
		apply_config(SAMPLE_W'(SAMPLE_MAX), 1'b1, 1'b1, RANGE_3000, 16'd0);
		send_sample('0);
		send_sample(SAMPLE_W'(SAMPLE_MAX));
		send_sample(10'd5);
		// unused range code takes the largest full scale
		drain_and_settle();
		apply_config(10'd300, 1'b1, 1'b1, RANGE_UNUSED, 16'd3);
		send_sample(10'd300);
		send_sample('0);
		send_sample(SAMPLE_W'(SAMPLE_MAX));
		send_sample(10'd100);
		send_sample(10'd200);
		send_sample(10'd50);
		// shorten the period below the count already reached
		drain_and_settle();
		apply_config('0, 1'b1, 1'b0, RANGE_2000, 16'd10);
		for (int k = 1; k <= 6; k++) send_sample(SAMPLE_W'(k * 10));
		drain_and_settle();
		apply_config('0, 1'b1, 1'b0, RANGE_2000, 16'd4);
		send_sample(10'd700);

		for (int mode = 0; mode < 3; mode++) begin
			for (int round = 0; round < ROUNDS; round++) begin
				drain_and_settle();
				send_idle_pct = sender_idle_pct[mode];
				recv_idle_pct <= receiver_idle_pct[mode];
				case ($urandom_range(9))
					0: period_pick = '0;
					1: period_pick = 16'd1;
					2: period_pick = COUNT_W'($urandom_range(40, 17));
					default: period_pick = COUNT_W'($urandom_range(16, 2));
				endcase
				apply_config(pick_offset(), 1'($urandom_range(1)), 1'($urandom_range(1)),
					2'($urandom_range(3)), period_pick);
				repeat (ROUND_ITEMS) send_sample(pick_sample());
			end
		end

		// long receiver hold-off with a report per sample fills the block
		drain_and_settle();
		apply_config(pick_offset(), 1'($urandom_range(1)), 1'($urandom_range(1)),
			2'($urandom_range(3)), 16'd1);
		long_hold_go <= 1'b1;
		repeat (PRESSURE_ITEMS) send_sample(pick_sample());

		drain_and_settle();
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
